>>> design/exr_pkg.sv
// ----------------------------------------------------------------------------
// exr_pkg: shared constants, types and helpers for the Euler XYZ rotator
// Holds format constants, the arctangent table and the pipeline item type.
// ----------------------------------------------------------------------------
package exr_pkg;

  localparam int CompW      = 32;
  localparam int AngW       = 18;
  localparam int Stages     = 16;
  localparam int StageW     = $clog2(Stages);
  localparam int TrigW      = 32;   // Q2.30 cosine and sine
  localparam int ZW         = 32;   // angle accumulator, degrees * 2^22
  localparam int FullTurn   = 92160;
  localparam int HalfTurn   = 46080;
  localparam int QuarterTurn = 23040;
  localparam int InvGainQ30 = 652032874;
  localparam int WideW      = CompW + 4;   // rotated components before clamping

  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [ZW-1:0]    zacc_t;
  typedef logic signed [WideW-1:0] wide_t;

  // One angle rotator lane: CORDIC x/y/z and the half-turn flip
  typedef struct packed {
    trig_t x;
    trig_t y;
    zacc_t z;
    logic  flip;
  } lane_t;

  // Item moving down the CORDIC chain
  typedef struct packed {
    logic [CompW-1:0] vx;
    logic [CompW-1:0] vy;
    logic [CompW-1:0] vz;
    lane_t            lx;
    lane_t            ly;
    lane_t            lz;
  } cell_t;

  function automatic zacc_t atan_q22(input int i);
    zacc_t t;
    case (i)
      0: t = 188743680; 1: t = 111421900; 2: t = 58872272; 3: t = 29884485;
      4: t = 15000234;  5: t = 7507429;   6: t = 3754631;  7: t = 1877430;
      8: t = 938729;    9: t = 469366;    10: t = 234683;  11: t = 117342;
      12: t = 58671;    13: t = 29335;    14: t = 14668;   15: t = 7334;
      16: t = 3667;     17: t = 1833;     18: t = 917;     19: t = 458;
      20: t = 229;      21: t = 115;      22: t = 57;      23: t = 29;
      24: t = 14;       25: t = 7;        26: t = 4;       27: t = 2;
      28: t = 1;
      default: t = '0;
    endcase
    return t;
  endfunction

  // round(a * b / 2^30), half up; a is at most WideW bits
  function automatic wide_t mul_q30(input wide_t a, input trig_t b);
    logic signed [WideW+TrigW-1:0] p;
    p = a * b + ((WideW+TrigW)'(1) <<< 29);
    return wide_t'(p >>> 30);
  endfunction

endpackage

>>> design/euler_xyz_vector_rotation_unit.sv
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotation_unit: rotate a Q16.16 vector about X, Y then Z
// Angle reduction, a 16-cell CORDIC chain and six multiply-round stages.
// ----------------------------------------------------------------------------
// One item enters per clock and results leave one per clock while the output
// is not stalled. On its way an item passes one reduction stage, sixteen
// CORDIC cells, six multiply stages (X, Y, Z rotations each take a product
// stage and a sum stage) and one clamp stage. The whole chain stalls together
// when the output is stalled and holds a valid result.
module euler_xyz_vector_rotation_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [exr_pkg::CompW-1:0]    vec_x,
  input  logic signed [exr_pkg::CompW-1:0]    vec_y,
  input  logic signed [exr_pkg::CompW-1:0]    vec_z,
  input  logic signed [exr_pkg::AngW-1:0]     angle_x,
  input  logic signed [exr_pkg::AngW-1:0]     angle_y,
  input  logic signed [exr_pkg::AngW-1:0]     angle_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [exr_pkg::CompW-1:0]    out_x,
  output logic signed [exr_pkg::CompW-1:0]    out_y,
  output logic signed [exr_pkg::CompW-1:0]    out_z,
  output logic                                saturated
);
  import exr_pkg::*;

  localparam int Lat = Stages + 8;
  localparam logic signed [AngW+1:0] RFull    = (AngW+2)'(FullTurn);
  localparam logic signed [AngW+1:0] RHalf    = (AngW+2)'(HalfTurn);
  localparam logic signed [AngW+1:0] RQuarter = (AngW+2)'(QuarterTurn);

  logic en;
  logic [Lat-1:0] vld;

  // advance whenever the last stage is empty or drained
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_valid};
    end
  end
  assign out_valid = vld[Lat-1];

  // reduce angle to [-90, 90] with a flip flag
  function automatic lane_t reduce(input logic signed [AngW-1:0] a);
    lane_t l;
    logic signed [AngW+1:0] r;
    r = {{2{a[AngW-1]}}, a};
    if (r > RHalf) r = r - RFull;
    else if (r <= -RHalf) r = r + RFull;
    if (r > RHalf) r = r - RFull;
    else if (r <= -RHalf) r = r + RFull;
    l.flip = 1'b0;
    if (r > RQuarter) begin
      r = r - RHalf; l.flip = 1'b1;
    end else if (r < -RQuarter) begin
      r = r + RHalf; l.flip = 1'b1;
    end
    l.x = trig_t'(InvGainQ30);
    l.y = '0;
    l.z = zacc_t'(r) <<< 14;
    return l;
  endfunction

  cell_t chain [0:Stages];

  // load the reduced angles into the head of the chain
  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].vx <= vec_x;
      chain[0].vy <= vec_y;
      chain[0].vz <= vec_z;
      chain[0].lx <= reduce(angle_x);
      chain[0].ly <= reduce(angle_y);
      chain[0].lz <= reduce(angle_z);
    end
  end

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    exr_cell u_cell (
      .clk(clk), .en(en), .stage(StageW'(g)), .d(chain[g]), .q(chain[g+1])
    );
  end

  function automatic trig_t fix(input trig_t v, input logic f);
    return f ? -v : v;
  endfunction

  trig_t cx, sx, cy, sy, cz, sz;
  assign cx = fix(chain[Stages].lx.x, chain[Stages].lx.flip);
  assign sx = fix(chain[Stages].lx.y, chain[Stages].lx.flip);
  assign cy = fix(chain[Stages].ly.x, chain[Stages].ly.flip);
  assign sy = fix(chain[Stages].ly.y, chain[Stages].ly.flip);
  assign cz = fix(chain[Stages].lz.x, chain[Stages].lz.flip);
  assign sz = fix(chain[Stages].lz.y, chain[Stages].lz.flip);

  // X rotation: products then sums
  wide_t a_ycx, a_zsx, a_ysx, a_zcx, a_x;
  trig_t a_cy, a_sy, a_cz, a_sz;
  wide_t b_y1, b_z1, b_x;
  trig_t b_cy, b_sy, b_cz, b_sz;
  wide_t c_xcy, c_zsy, c_zcy, c_xsy, c_y1;
  trig_t c_cz, c_sz;
  wide_t d_x2, d_z2, d_y1;
  trig_t d_cz, d_sz;
  wide_t e_xcz, e_ysz, e_xsz, e_ycz, e_z2;
  wide_t f_x3, f_y3, f_z2;

  function automatic wide_t sx_ext(input logic [CompW-1:0] v);
    return wide_t'($signed(v));
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      a_ycx <= mul_q30(sx_ext(chain[Stages].vy), cx);
      a_zsx <= mul_q30(sx_ext(chain[Stages].vz), sx);
      a_ysx <= mul_q30(sx_ext(chain[Stages].vy), sx);
      a_zcx <= mul_q30(sx_ext(chain[Stages].vz), cx);
      a_x <= sx_ext(chain[Stages].vx);
      a_cy <= cy; a_sy <= sy; a_cz <= cz; a_sz <= sz;

      b_y1 <= a_ycx - a_zsx;
      b_z1 <= a_ysx + a_zcx;
      b_x <= a_x;
      b_cy <= a_cy; b_sy <= a_sy; b_cz <= a_cz; b_sz <= a_sz;

      // Y rotation
      c_xcy <= mul_q30(b_x, b_cy);
      c_zsy <= mul_q30(b_z1, b_sy);
      c_zcy <= mul_q30(b_z1, b_cy);
      c_xsy <= mul_q30(b_x, b_sy);
      c_y1 <= b_y1; c_cz <= b_cz; c_sz <= b_sz;

      d_x2 <= c_xcy + c_zsy;
      d_z2 <= c_zcy - c_xsy;
      d_y1 <= c_y1; d_cz <= c_cz; d_sz <= c_sz;

      // Z rotation
      e_xcz <= mul_q30(d_x2, d_cz);
      e_ysz <= mul_q30(d_y1, d_sz);
      e_xsz <= mul_q30(d_x2, d_sz);
      e_ycz <= mul_q30(d_y1, d_cz);
      e_z2 <= d_z2;

      f_x3 <= e_xcz - e_ysz;
      f_y3 <= e_xsz + e_ycz;
      f_z2 <= e_z2;
    end
  end

  // clamp to the component range
  localparam wide_t Hi = (wide_t'(1) <<< (CompW-1)) - wide_t'(1);
  localparam wide_t Lo = -Hi - wide_t'(1);
  logic sx3, sy3, sz2;
  assign sx3 = (f_x3 > Hi) || (f_x3 < Lo);
  assign sy3 = (f_y3 > Hi) || (f_y3 < Lo);
  assign sz2 = (f_z2 > Hi) || (f_z2 < Lo);

  function automatic logic [CompW-1:0] clamp(input wide_t v);
    if (v > Hi) return CompW'(Hi);
    if (v < Lo) return CompW'(Lo);
    return CompW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= clamp(f_x3);
      out_y <= clamp(f_y3);
      out_z <= clamp(f_z2);
      saturated <= sx3 | sy3 | sz2;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(saturated))
    else $error("result changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !in_valid |=> !vld[0])
    else $error("bubble lost");
endmodule

>>> design/exr_cell.sv
// ----------------------------------------------------------------------------
// exr_cell: one CORDIC iteration for all three angle lanes
// Shifts by a fixed amount set by the cell's place in the chain.
// ----------------------------------------------------------------------------
module exr_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [exr_pkg::StageW-1:0]  stage,
  input  exr_pkg::cell_t              d,
  output exr_pkg::cell_t              q
);
  import exr_pkg::*;

  function automatic lane_t step(input lane_t l);
    lane_t r;
    zacc_t a;
    a = atan_q22(int'(stage));
    r = l;
    if (!l.z[ZW-1]) begin
      r.x = l.x - (l.y >>> stage);
      r.y = l.y + (l.x >>> stage);
      r.z = l.z - a;
    end else begin
      r.x = l.x + (l.y >>> stage);
      r.y = l.y - (l.x >>> stage);
      r.z = l.z + a;
    end
    return r;
  endfunction

  // advance one iteration when the chain moves
  always_ff @(posedge clk) begin
    if (en) begin
      q.vx <= d.vx;
      q.vy <= d.vy;
      q.vz <= d.vz;
      q.lx <= step(d.lx);
      q.ly <= step(d.ly);
      q.lz <= step(d.lz);
    end
  end
endmodule
